[sv/convex_hull_monotone_chain_macros.svh]
// assertion macros for the convex hull block
`ifndef CONVEX_HULL_MONOTONE_CHAIN_MACROS_SVH
`define CONVEX_HULL_MONOTONE_CHAIN_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CHM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/chm_pkg.sv]
// shared types and constants for the convex hull block
`default_nettype none

package chm_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int COORD_BITS_DEF = 16;
    localparam int RESULT_CAP     = 32;
    localparam int MIN_POINTS     = 3;
    localparam int EMW            = $clog2(RESULT_CAP + 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_CLOSE,
        S_H_LOAD,
        S_H_GET,
        S_H_CHK,
        S_H_T1,
        S_H_T2,
        S_H_DIFF,
        S_H_M1,
        S_H_M2,
        S_H_CMP,
        S_H_PUSH,
        S_E_RD,
        S_E_PT,
        S_E_LD,
        S_E_ERR,
        S_E_WAIT
    } ctrl_state_t;

    typedef struct packed {
        logic latch_in;
        logic ins_rd;
        logic ins_shift;
        logic ins_place;
        logic hull_init;
        logic ld_cand;
        logic get_cand;
        logic rd_top;
        logic rd_sec;
        logic get_a;
        logic calc_diff;
        logic mul1;
        logic mul2;
        logic pop;
        logic push;
        logic emit_rd;
        logic emit_pt;
        logic emit_load;
        logic emit_err;
        logic emit_next;
        logic close;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic set_end;
        logic j_zero;
        logic cnt_lt3;
        logic precedes;
        logic k_ge_lim;
        logic turn_le;
        logic hull_done;
        logic out_taken;
        logic out_last;
    } dp_stat_t;

endpackage

`default_nettype wire

[sv/chm_ctrl.sv]
// sequencer for insertion, hull passes and vertex output
`default_nettype none

module chm_ctrl
    import chm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    logic        accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = stat.full ? S_CLOSE : S_INS_CHK;
                end
            end
            S_INS_CHK: state_next = stat.j_zero ? S_CLOSE : S_INS_CMP;
            S_INS_CMP: state_next = stat.precedes ? S_INS_CHK : S_CLOSE;
            S_CLOSE:
            begin
                if (!stat.set_end)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.cnt_lt3)
                begin
                    state_next = S_E_ERR;
                end
                else
                begin
                    state_next = S_H_LOAD;
                end
            end
            S_H_LOAD:  state_next = S_H_GET;
            S_H_GET:   state_next = S_H_CHK;
            S_H_CHK:   state_next = stat.k_ge_lim ? S_H_T1 : S_H_PUSH;
            S_H_T1:    state_next = S_H_T2;
            S_H_T2:    state_next = S_H_DIFF;
            S_H_DIFF:  state_next = S_H_M1;
            S_H_M1:    state_next = S_H_M2;
            S_H_M2:    state_next = S_H_CMP;
            S_H_CMP:   state_next = stat.turn_le ? S_H_CHK : S_H_PUSH;
            S_H_PUSH:  state_next = stat.hull_done ? S_E_RD : S_H_LOAD;
            S_E_RD:    state_next = S_E_PT;
            S_E_PT:    state_next = S_E_LD;
            S_E_LD:    state_next = S_E_WAIT;
            S_E_ERR:   state_next = S_E_WAIT;
            S_E_WAIT:
            begin
                if (stat.out_taken)
                begin
                    state_next = stat.out_last ? S_IDLE : S_E_RD;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:    cmd.latch_in = accept;
            S_INS_CHK:
            begin
                cmd.ins_place = stat.j_zero;
                cmd.ins_rd    = !stat.j_zero;
            end
            S_INS_CMP:
            begin
                cmd.ins_shift = stat.precedes;
                cmd.ins_place = !stat.precedes;
            end
            S_CLOSE:   cmd.hull_init = stat.set_end && !stat.cnt_lt3;
            S_H_LOAD:  cmd.ld_cand = 1'b1;
            S_H_GET:   cmd.get_cand = 1'b1;
            S_H_CHK:   cmd.rd_top = 1'b1;
            S_H_T1:    cmd.rd_sec = 1'b1;
            S_H_T2:    cmd.get_a = 1'b1;
            S_H_DIFF:  cmd.calc_diff = 1'b1;
            S_H_M1:    cmd.mul1 = 1'b1;
            S_H_M2:    cmd.mul2 = 1'b1;
            S_H_CMP:   cmd.pop = stat.turn_le;
            S_H_PUSH:  cmd.push = 1'b1;
            S_E_RD:    cmd.emit_rd = 1'b1;
            S_E_PT:    cmd.emit_pt = 1'b1;
            S_E_LD:    cmd.emit_load = 1'b1;
            S_E_ERR:   cmd.emit_err = 1'b1;
            S_E_WAIT:
            begin
                cmd.close     = stat.out_taken && stat.out_last;
                cmd.emit_next = stat.out_taken && !stat.out_last;
            end
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[sv/chm_datapath.sv]
// point store, index stack, turn test and output registers
`default_nettype none

module chm_datapath
    import chm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dp_cmd_t                      cmd,
    output dp_stat_t                          stat,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    input  wire logic                         set_end,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [COORD_BITS-1:0]      hull_x,
    output logic signed [COORD_BITS-1:0]      hull_y,
    output logic                              run_end,
    output logic                              too_few,
    output logic                              overflowed
);

    localparam int CB   = COORD_BITS;
    localparam int IDXW = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SAW  = $clog2(2 * MAX_POINTS);
    localparam int KW   = $clog2(2 * MAX_POINTS + 1);
    localparam int DW   = CB + 1;
    localparam int PW   = 2 * DW;

    // memories: sorted points as {x, y}, stack of point indices
    logic [2*CB-1:0] pstore [MAX_POINTS];
    logic [IDXW-1:0] stk    [2*MAX_POINTS];

    logic [2*CB-1:0] prd_reg;
    logic [IDXW-1:0] srd_reg;
    logic [IDXW-1:0] paddr;
    logic [SAW-1:0]  saddr;
    logic            pwe;
    logic [2*CB-1:0] pwdata;

    logic signed [CB-1:0] px_reg, py_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic                 end_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 ovf_reg;
    logic [IDXW-1:0]      j_reg;
    logic [IDXW-1:0]      cand_reg;
    logic                 upper_reg;
    logic [KW-1:0]        k_reg, fk_reg;
    logic [EMW-1:0]       e_reg;

    logic signed [DW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;

    logic                 ovld_reg, rend_reg, tf_reg, ov_reg;
    logic signed [CB-1:0] hx_reg, hy_reg;

    logic signed [CB-1:0] qx, qy, ox, oy;
    logic [31:0]          km1;
    logic [EMW-1:0]       m_w;
    logic                 last_cand;

    assign qx = prd_reg[2*CB-1:CB];
    assign qy = prd_reg[CB-1:0];
    assign ox = qx;
    assign oy = qy;

    // point store read address
    always_comb
    begin
        if (cmd.ins_rd)
        begin
            paddr = j_reg - IDXW'(1);
        end
        else if (cmd.ld_cand)
        begin
            paddr = cand_reg;
        end
        else
        begin
            paddr = srd_reg;
        end
    end

    always_comb
    begin
        if (cmd.rd_top)
        begin
            saddr = SAW'(k_reg - KW'(1));
        end
        else if (cmd.rd_sec)
        begin
            saddr = SAW'(k_reg - KW'(2));
        end
        else
        begin
            saddr = SAW'(e_reg);
        end
    end

    assign pwe    = cmd.ins_shift || cmd.ins_place;
    assign pwdata = cmd.ins_shift ? prd_reg : {px_reg, py_reg};

    always_ff @(posedge clk)
    begin
        if (pwe)
        begin
            pstore[j_reg] <= pwdata;
        end
        prd_reg <= pstore[paddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stk[SAW'(k_reg)] <= cand_reg;
        end
        srd_reg <= stk[saddr];
    end

    // vertex count, capped
    assign km1 = 32'(k_reg) - 32'd1;
    assign m_w = (km1 > 32'(RESULT_CAP)) ? EMW'(RESULT_CAP) : EMW'(km1);

    assign last_cand = upper_reg ? (cand_reg == '0)
                                 : (cand_reg == IDXW'(cnt_reg - CW'(1)));

    always_comb
    begin
        stat.full      = (cnt_reg == CW'(MAX_POINTS));
        stat.set_end   = end_reg;
        stat.j_zero    = (j_reg == '0);
        stat.cnt_lt3   = (cnt_reg < CW'(MIN_POINTS));
        stat.precedes  = (px_reg < qx) || ((px_reg == qx) && (py_reg < qy));
        stat.k_ge_lim  = upper_reg ? (k_reg >= fk_reg) : (k_reg >= KW'(2));
        stat.turn_le   = (p1_reg <= p2_reg);
        stat.hull_done = upper_reg && last_cand;
        stat.out_taken = ovld_reg && !out_stall;
        stat.out_last  = rend_reg;
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
            fk_reg    <= '0;
            j_reg     <= '0;
            cand_reg  <= '0;
            upper_reg <= 1'b0;
            e_reg     <= '0;
            end_reg   <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                end_reg <= set_end;
                j_reg   <= IDXW'(cnt_reg);
                if (cnt_reg == CW'(MAX_POINTS))
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.ins_shift)
            begin
                j_reg <= j_reg - IDXW'(1);
            end
            if (cmd.ins_place)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.hull_init)
            begin
                k_reg     <= '0;
                cand_reg  <= '0;
                upper_reg <= 1'b0;
                e_reg     <= '0;
            end
            if (cmd.pop)
            begin
                k_reg <= k_reg - KW'(1);
            end
            if (cmd.push)
            begin
                k_reg <= k_reg + KW'(1);
                if (!upper_reg && last_cand)
                begin
                    upper_reg <= 1'b1;
                    fk_reg    <= k_reg + KW'(2);
                    cand_reg  <= IDXW'(cnt_reg - CW'(2));
                end
                else if (upper_reg)
                begin
                    cand_reg <= cand_reg - IDXW'(1);
                end
                else
                begin
                    cand_reg <= cand_reg + IDXW'(1);
                end
            end
            if (cmd.emit_next)
            begin
                e_reg <= e_reg + EMW'(1);
            end
            if (cmd.emit_load || cmd.emit_err)
            begin
                ovld_reg <= 1'b1;
            end
            else if (stat.out_taken)
            begin
                ovld_reg <= 1'b0;
            end
            if (cmd.close)
            begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
                k_reg   <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
        if (cmd.get_cand)
        begin
            bx_reg <= qx;
            by_reg <= qy;
        end
        if (cmd.get_a)
        begin
            ax_reg <= qx;
            ay_reg <= qy;
        end
        if (cmd.calc_diff)
        begin
            d1x_reg <= DW'(ax_reg) - DW'(ox);
            d1y_reg <= DW'(ay_reg) - DW'(oy);
            d2x_reg <= DW'(bx_reg) - DW'(ox);
            d2y_reg <= DW'(by_reg) - DW'(oy);
        end
        // the two cross products are formed in separate states
        if (cmd.mul1)
        begin
            p1_reg <= PW'(d1x_reg) * PW'(d2y_reg);
        end
        if (cmd.mul2)
        begin
            p2_reg <= PW'(d1y_reg) * PW'(d2x_reg);
        end
        if (cmd.emit_load)
        begin
            hx_reg   <= qx;
            hy_reg   <= qy;
            rend_reg <= ((e_reg + EMW'(1)) == m_w);
            tf_reg   <= 1'b0;
            ov_reg   <= ovf_reg;
        end
        if (cmd.emit_err)
        begin
            hx_reg   <= '0;
            hy_reg   <= '0;
            rend_reg <= 1'b1;
            tf_reg   <= 1'b1;
            ov_reg   <= ovf_reg;
        end
    end

    assign out_valid  = ovld_reg;
    assign hull_x     = hx_reg;
    assign hull_y     = hy_reg;
    assign run_end    = rend_reg;
    assign too_few    = tf_reg;
    assign overflowed = ov_reg;

endmodule

`default_nettype wire

[sv/convex_hull_monotone_chain.sv]
// top level of the monotone chain convex hull block
`default_nettype none

// Takes one point per request and keeps the set sorted by x, then y, in a store of
// MAX_POINTS entries; set_end closes the set and the hull comes out as one request
// per vertex, last one flagged with run_end, too_few set on a lone result when fewer
// than three points were stored. A point is inserted by moving each stored entry
// that sorts after it up by one place. The closing point then runs two stack passes
// of turn tests and pushes, the two cross products formed in separate states with
// registered memory reads, with at most about 4*MAX_POINTS tests per set; each vertex
// is then read out and held until the receiver takes it. No new point is taken until
// the last result of a set has been taken. No clearing pass after reset.
module convex_hull_monotone_chain
    import chm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    input  wire logic                         set_end,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [COORD_BITS-1:0]      hull_x,
    output logic signed [COORD_BITS-1:0]      hull_y,
    output logic                              run_end,
    output logic                              too_few,
    output logic                              overflowed
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    chm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    chm_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .point_x    (point_x),
        .point_y    (point_y),
        .set_end    (set_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hull_x     (hull_x),
        .hull_y     (hull_y),
        .run_end    (run_end),
        .too_few    (too_few),
        .overflowed (overflowed)
    );

endmodule

`default_nettype wire

[sv/chm_checker.sv]
// port-level checks for the convex hull block, bound to the top level
`default_nettype none

`include "convex_hull_monotone_chain_macros.svh"

module chm_checker #(
    parameter int COORD_BITS = 16
)
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic signed [COORD_BITS-1:0] point_x,
    input wire logic signed [COORD_BITS-1:0] point_y,
    input wire logic                         set_end,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic signed [COORD_BITS-1:0] hull_x,
    input wire logic signed [COORD_BITS-1:0] hull_y,
    input wire logic                         run_end,
    input wire logic                         too_few,
    input wire logic                         overflowed
);

    // error result is a lone zero vertex
    `CHM_ASSERT_NOW(a_too_few_form, out_valid && too_few, run_end && hull_x == '0 && hull_y == '0, "too_few result malformed")

    // no point is taken while a result waits
    `CHM_ASSERT_NOW(a_no_accept_while_out, out_valid, in_stall, "input taken while result pending")

    // a point that does not close the set gives no result
    `CHM_ASSERT_NEXT(a_open_no_result, in_valid && !in_stall && !set_end, !out_valid, "result after open point")

    // stalled result holds
    `CHM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hull_x) && $stable(hull_y) && $stable(run_end) && $stable(overflowed), "stalled result changed")

endmodule

bind convex_hull_monotone_chain chm_checker #(.COORD_BITS(COORD_BITS)) u_chk (.*);

`default_nettype wire

[tb/tb_convex_hull_monotone_chain.sv]
// testbench for the monotone chain convex hull block
`timescale 1ns / 1ps
`default_nettype none

module tb_convex_hull_monotone_chain;
    import chm_pkg::*;

    localparam int CAP = MAX_POINTS_DEF;
    localparam int HOLD_CYCLES = 6000;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } point_req_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic               short_set;
        logic               dropped;
    } vertex_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] point_x = '0;
    logic signed [15:0] point_y = '0;
    logic set_end = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] hull_x, hull_y;
    logic run_end, too_few, overflowed;

    point_req_t  pending_points[$];
    vertex_res_t expected_vertices[$];

    // predictor state
    logic signed [15:0] sorted_x[CAP];
    logic signed [15:0] sorted_y[CAP];
    int unsigned stored_cnt = 0;
    bit          lost_points = 0;
    int          chain[2*CAP];

    int  mismatches = 0;
    int  sent_count = 0;
    bit  stim_done = 0;
    bit  quiet = 0;
    bit  hold_long = 0;
    int  hold_cnt = 0;
    bit  pause_send = 0;
    int  send_gap = 0;
    int  recv_gap = 0;

    convex_hull_monotone_chain dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .set_end(set_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .hull_x(hull_x), .hull_y(hull_y), .run_end(run_end),
        .too_few(too_few), .overflowed(overflowed)
    );

    always #1 clk = ~clk;

    function automatic longint cross_turn(int o, int a, int b);
        longint ox, oy;
        ox = sorted_x[o];
        oy = sorted_y[o];
        return (longint'(sorted_x[a]) - ox) * (longint'(sorted_y[b]) - oy)
             - (longint'(sorted_y[a]) - oy) * (longint'(sorted_x[b]) - ox);
    endfunction

    task automatic predict_hull(point_req_t p);
        int j, k, i, floor_k, m;
        vertex_res_t v;
        if (stored_cnt < CAP)
        begin
            j = stored_cnt;
            while (j > 0 && (p.x < sorted_x[j-1] ||
                   (p.x == sorted_x[j-1] && p.y < sorted_y[j-1])))
            begin
                sorted_x[j] = sorted_x[j-1];
                sorted_y[j] = sorted_y[j-1];
                j--;
            end
            sorted_x[j] = p.x;
            sorted_y[j] = p.y;
            stored_cnt++;
        end
        else
            lost_points = 1;
        if (!p.last)
            return;
        if (stored_cnt < MIN_POINTS)
        begin
            v = '{x: 0, y: 0, last: 1, short_set: 1, dropped: lost_points};
            expected_vertices.insert(expected_vertices.size(), v);
        end
        else
        begin
            k = 0;
            for (i = 0; i < stored_cnt; i++)
            begin
                while (k >= 2 && cross_turn(chain[k-2], chain[k-1], i) <= 0)
                    k--;
                chain[k++] = i;
            end
            floor_k = k + 1;
            for (i = stored_cnt - 1; i > 0; i--)
            begin
                while (k >= floor_k && cross_turn(chain[k-2], chain[k-1], i-1) <= 0)
                    k--;
                chain[k++] = i - 1;
            end
            m = k - 1;
            if (m > RESULT_CAP)
                m = RESULT_CAP;
            for (j = 0; j < m; j++)
            begin
                v = '{x: sorted_x[chain[j]], y: sorted_y[chain[j]],
                      last: (j + 1 == m), short_set: 0, dropped: lost_points};
                expected_vertices.insert(expected_vertices.size(), v);
            end
        end
        stored_cnt = 0;
        lost_points = 0;
    endtask

    // driver
    always @(posedge clk)
    begin
        point_req_t p;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_hull('{x: point_x, y: point_y, last: set_end});
                sent_count <= sent_count + 1;
            end
            if (in_valid && in_stall)
                ;
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!pause_send && pending_points.size() > 0
                     && !(in_valid && !in_stall && pending_points.size() == 0))
            begin
                p = pending_points.pop_front();
                in_valid <= 1'b1;
                point_x <= p.x;
                point_y <= p.y;
                set_end <= p.last;
                if (!quiet && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 17);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall bursts; the long hold is counted here
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_long && hold_cnt < HOLD_CYCLES)
            begin
                hold_cnt <= hold_cnt + 1;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                recv_gap <= $urandom_range(0, 16);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        vertex_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex x=%0d y=%0d", hull_x, hull_y);
            end
            else
            begin
                want = expected_vertices.pop_front();
                if (hull_x !== want.x || hull_y !== want.y || run_end !== want.last
                    || too_few !== want.short_set || overflowed !== want.dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch: exp %0d,%0d e%0b f%0b o%0b got %0d,%0d e%0b f%0b o%0b",
                                 want.x, want.y, want.last, want.short_set, want.dropped,
                                 hull_x, hull_y, run_end, too_few, overflowed);
                end
            end
        end
    end

    function automatic logic signed [15:0] rand_coord(int spread);
        if (spread == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 2*spread) - spread);
    endfunction

    task automatic queue_set(int n, int spread);
        for (int i = 0; i < n; i++)
            pending_points.insert(pending_points.size(),
                                  '{x: rand_coord(spread), y: rand_coord(spread),
                                    last: (i == n - 1)});
    endtask

    task automatic queue_pt(int x, int y, bit last);
        pending_points.insert(pending_points.size(), '{x: 16'(x), y: 16'(y), last: last});
    endtask

    initial
    begin
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // directed: lone point, two points, extremes, collinear, repeated, square
        queue_pt(-32768, 32767, 1);
        queue_pt(32767, -32768, 0); queue_pt(-32768, -32768, 1);
        queue_pt(-32768, -32768, 0); queue_pt(32767, -32768, 0);
        queue_pt(32767, 32767, 0); queue_pt(-32768, 32767, 1);
        queue_pt(0, 0, 0); queue_pt(1, 1, 0); queue_pt(2, 2, 0); queue_pt(3, 3, 1);
        queue_pt(5, 5, 0); queue_pt(5, 5, 0); queue_pt(5, 5, 1);
        queue_pt(0, 0, 0); queue_pt(4, 0, 0); queue_pt(2, 2, 0); queue_pt(2, -2, 0);
        queue_pt(2, 0, 1);
        target = sent_count + pending_points.size();
        wait (sent_count == target && expected_vertices.size() == 0);
        // overflow: more than capacity, closing point dropped too
        queue_set(CAP + 3, 0);
        // circle-ish set giving a long hull
        for (int i = 0; i < CAP; i++)
            queue_pt(((i * 7919) % 2000) - 1000, (i * i) % 997 - 500, i == CAP - 1);
        for (int i = 0; i < CAP; i++)
            queue_pt(i * 100 - 1600, (i - 16) * (i - 16) * 10, i == CAP - 1);
        // receiver holds off long while sender keeps offering
        queue_set(CAP, 0);
        queue_set(8, 20);
        target = sent_count + pending_points.size();
        hold_long = 1;
        wait (hold_cnt == HOLD_CYCLES);
        hold_long = 0;
        wait (sent_count == target && expected_vertices.size() == 0);
        while (sent_count < 430)
        begin
            case ($urandom_range(0, 5))
                0: queue_set($urandom_range(1, 3), 0);
                1: queue_set($urandom_range(3, 12), 3);
                2: queue_set($urandom_range(CAP - 2, CAP + 4), 0);
                default: queue_set($urandom_range(3, 16), 0);
            endcase
            target = sent_count + pending_points.size();
            wait (sent_count == target);
        end
        quiet = 1;
        for (int s = 0; s < 6; s++)
            queue_set($urandom_range(3, 10), 0);
        target = sent_count + pending_points.size();
        wait (sent_count == target && expected_vertices.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_vertices.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
